### hdl/crc16cfd_pkg.sv
package crc16cfd_pkg;

  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [7:0]  HEAD_FIRST  = 8'hEB;
  localparam logic [7:0]  HEAD_SECOND = 8'h90;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD      = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef enum logic [8:0] {
    ST_HUNT     = 9'b0_0000_0001,
    ST_HEAD2    = 9'b0_0000_0010,
    ST_ID_LO    = 9'b0_0000_0100,
    ST_ID_HI    = 9'b0_0000_1000,
    ST_SYNC     = 9'b0_0001_0000,
    ST_LEN_LO   = 9'b0_0010_0000,
    ST_LEN_HI   = 9'b0_0100_0000,
    ST_PAYLOAD  = 9'b0_1000_0000,
    ST_CRC_HI   = 9'b1_0000_0000
  } stage_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/crc16_checked_frame_deframer_top.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_byte: one received word
// out      output     out_valid / out_ready kind, data byte, index, id, sync, length
//
// One word per cycle when not stalled; a result appears in the cycle after its word.
// The parser state and the byte-wide CRC update sit before a single result register.
// A stalled result blocks new words only while out_ready stays low.
// Reset is synchronous and active low; it returns the parser to hunting for a header.
module crc16_checked_frame_deframer_top
  import crc16cfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_index,
  output logic [15:0] out_frame_id,
  output logic [7:0]  out_sync_code,
  output logic [15:0] out_payload_length
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  stage_t           stage_r, stage_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [7:0]       sync_r, sync_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  logic             out_valid_r;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [7:0]       index_r, index_nxt;
  logic [15:0]      fid_r;
  logic [7:0]       fsync_r;
  logic [15:0]      flen_r;

  logic             emit;
  logic             accept;
  logic [16:0]      cnt_ext;
  logic [15:0]      crc_upd;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign cnt_ext  = 17'(cnt_r);
  assign crc_upd  = crc_byte(crc_r, in_byte);

  always_comb begin
    stage_nxt  = stage_r;
    crc_nxt    = crc_r;
    id_nxt     = id_r;
    sync_nxt   = sync_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_lo_nxt = crc_lo_r;
    emit       = 1'b0;
    kind_nxt   = KIND_PAYLOAD;
    data_nxt   = 8'h00;
    index_nxt  = 8'h00;
    case (stage_r)
      ST_HUNT: begin
        if (in_byte == HEAD_FIRST) begin
          crc_nxt   = crc_byte(16'h0000, in_byte);
          stage_nxt = ST_HEAD2;
        end
      end
      ST_HEAD2: begin
        if (in_byte == HEAD_SECOND) begin
          crc_nxt   = crc_upd;
          stage_nxt = ST_ID_LO;
        end else begin
          stage_nxt = ST_HUNT;
        end
      end
      ST_ID_LO: begin
        id_nxt    = {id_r[15:8], in_byte};
        crc_nxt   = crc_upd;
        stage_nxt = ST_ID_HI;
      end
      ST_ID_HI: begin
        id_nxt    = {in_byte, id_r[7:0]};
        crc_nxt   = crc_upd;
        stage_nxt = ST_SYNC;
      end
      ST_SYNC: begin
        sync_nxt  = in_byte;
        crc_nxt   = crc_upd;
        stage_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        len_nxt   = {len_r[15:8], in_byte};
        cnt_nxt   = '0;
        crc_nxt   = crc_upd;
        stage_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_nxt = {in_byte, len_r[7:0]};
        cnt_nxt = '0;
        crc_nxt = crc_upd;
        if (len_nxt > 16'(MAX_PAYLOAD)) begin
          emit      = 1'b1;
          kind_nxt  = KIND_TOO_LONG;
          stage_nxt = ST_HUNT;
        end else begin
          stage_nxt = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (cnt_ext < {1'b0, len_r}) begin
          emit      = 1'b1;
          kind_nxt  = KIND_PAYLOAD;
          data_nxt  = in_byte;
          index_nxt = cnt_ext[7:0];
          crc_nxt   = crc_upd;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          crc_lo_nxt = in_byte;
          stage_nxt  = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        emit      = 1'b1;
        kind_nxt  = (crc_r == {in_byte, crc_lo_r}) ? KIND_GOOD : KIND_BAD;
        stage_nxt = ST_HUNT;
      end
      default: begin
        stage_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        stage_r     <= stage_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      crc_r    <= crc_nxt;
      id_r     <= id_nxt;
      sync_r   <= sync_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_lo_r <= crc_lo_nxt;
      if (emit) begin
        kind_r  <= kind_nxt;
        data_r  <= data_nxt;
        index_r <= index_nxt;
        fid_r   <= id_nxt;
        fsync_r <= sync_nxt;
        flen_r  <= len_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_data_byte      = data_r;
  assign out_byte_index     = index_r;
  assign out_frame_id       = fid_r;
  assign out_sync_code      = fsync_r;
  assign out_payload_length = flen_r;

endmodule

### verif/tb_crc16_checked_frame_deframer_top.sv
`timescale 1ns / 100ps

module tb_crc16_checked_frame_deframer_top;
  import crc16cfd_pkg::*;

  localparam int MAX_PAYLOAD = 256;
  localparam int RANDOM_WORDS = 2000;

  typedef struct {
    logic [7:0] value;
    int         gap;
    bit         hold;
  } word_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [15:0] id;
    logic [7:0]  sync;
    logic [15:0] len;
  } frame_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_byte_index;
  logic [15:0] out_frame_id;
  logic [7:0]  out_sync_code;
  logic [15:0] out_payload_length;

  word_t        pending_words[$];
  frame_event_t due_events[$];
  frame_event_t want;
  int           fail_count = 0;
  int           words_queued = 0;
  int           send_quiet = 0;
  int           ready_quiet = 0;
  int           stall_left = 0;
  bit           drain_next = 1'b0;

  stage_t      p_stage = ST_HUNT;
  logic [15:0] p_crc = 16'h0000;
  logic [15:0] p_id = 16'h0000;
  logic [7:0]  p_sync = 8'h00;
  logic [15:0] p_len = 16'h0000;
  logic [8:0]  p_count = 9'd0;
  logic [7:0]  p_crc_lo = 8'h00;

  crc16_checked_frame_deframer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_byte_index    (out_byte_index),
    .out_frame_id      (out_frame_id),
    .out_sync_code     (out_sync_code),
    .out_payload_length(out_payload_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] kermit_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones, and now and then a long run with no gaps.
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic void note_event(input kind_t k, input logic [7:0] d, input logic [7:0] i);
    due_events.push_back('{k, d, i, p_id, p_sync, p_len});
  endfunction

  function automatic void parse_word(input logic [7:0] b);
    case (p_stage)
      ST_HUNT: begin
        if (b == HEAD_FIRST) begin
          p_crc = kermit_update(16'h0000, b);
          p_stage = ST_HEAD2;
        end
      end
      ST_HEAD2: begin
        if (b == HEAD_SECOND) begin
          p_crc = kermit_update(p_crc, b);
          p_stage = ST_ID_LO;
        end else begin
          p_stage = ST_HUNT;
        end
      end
      ST_ID_LO: begin
        p_id[7:0] = b;
        p_crc = kermit_update(p_crc, b);
        p_stage = ST_ID_HI;
      end
      ST_ID_HI: begin
        p_id[15:8] = b;
        p_crc = kermit_update(p_crc, b);
        p_stage = ST_SYNC;
      end
      ST_SYNC: begin
        p_sync = b;
        p_crc = kermit_update(p_crc, b);
        p_stage = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        p_len[7:0] = b;
        p_count = 9'd0;
        p_crc = kermit_update(p_crc, b);
        p_stage = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        p_len[15:8] = b;
        p_count = 9'd0;
        p_crc = kermit_update(p_crc, b);
        if (p_len > 16'(MAX_PAYLOAD)) begin
          note_event(KIND_TOO_LONG, 8'h00, 8'h00);
          p_stage = ST_HUNT;
        end else begin
          p_stage = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (16'(p_count) < p_len) begin
          note_event(KIND_PAYLOAD, b, p_count[7:0]);
          p_crc = kermit_update(p_crc, b);
          p_count = p_count + 9'd1;
        end else begin
          p_crc_lo = b;
          p_stage = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        note_event(({b, p_crc_lo} == p_crc) ? KIND_GOOD : KIND_BAD, 8'h00, 8'h00);
        p_stage = ST_HUNT;
      end
      default: begin
        p_stage = ST_HUNT;
      end
    endcase
  endfunction

  task automatic send(input logic [7:0] b);
    pending_words.push_back('{b, idle_len(send_quiet), drain_next});
    drain_next = 1'b0;
    words_queued++;
  endtask

  task automatic send_tracked(input logic [7:0] b, inout logic [15:0] crc);
    send(b);
    crc = kermit_update(crc, b);
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [7:0] sync,
                            input logic [15:0] len, input bit corrupt);
    logic [15:0] crc;
    crc = 16'h0000;
    send_tracked(HEAD_FIRST, crc);
    send_tracked(HEAD_SECOND, crc);
    send_tracked(id[7:0], crc);
    send_tracked(id[15:8], crc);
    send_tracked(sync, crc);
    send_tracked(len[7:0], crc);
    send_tracked(len[15:8], crc);
    if (len > 16'(MAX_PAYLOAD)) return;
    repeat (len) send_tracked(8'($urandom_range(0, 255)), crc);
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
    send(crc[7:0]);
    send(crc[15:8]);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_word(in_byte);
      if (!in_valid || in_ready) begin
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_words[0].hold && due_events.size() != 0) begin
          in_valid <= 1'b0;
        end else if (pending_words[0].gap > 0) begin
          pending_words[0].gap = pending_words[0].gap - 1;
          in_valid <= 1'b0;
        end else begin
          in_byte <= pending_words[0].value;
          in_valid <= 1'b1;
          void'(pending_words.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        $error("unexpected result: kind %0d, id 0x%0h", out_kind, out_frame_id);
        fail_count++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_kind));
        check_field("data_byte", 16'(want.data), 16'(out_data_byte));
        check_field("byte_index", 16'(want.index), 16'(out_byte_index));
        check_field("frame_id", want.id, out_frame_id);
        check_field("sync_code", 16'(want.sync), 16'(out_sync_code));
        check_field("payload_length", want.len, out_payload_length);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = idle_len(ready_quiet);
    end
  end

  initial begin
    int r;
    int len;
    send(HEAD_FIRST);
    send(8'h00);
    send_frame(16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);
    send_frame(16'h0000, 8'h00, 16'd1, 1'b0);
    send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 16'd0, 1'b1);

    drain_next = 1'b1;
    while (words_queued < RANDOM_WORDS) begin
      if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6)) begin
          send(($urandom_range(0, 4) == 0) ? HEAD_FIRST : 8'($urandom_range(0, 255)));
        end
      end else if (r < 13) begin
        send(HEAD_FIRST);
        send(($urandom_range(0, 2) == 0) ? HEAD_FIRST : 8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(0, 8);
        else if (r < 82) len = $urandom_range(9, 40);
        else if (r < 86) len = 0;
        else if (r < 88) len = $urandom_range(0, 1) ? MAX_PAYLOAD : $urandom_range(250, 255);
        else if (r < 94) len = $urandom_range(0, 1) ? MAX_PAYLOAD + 1 : $urandom_range(258, 65535);
        else len = $urandom_range(41, 120);
        send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 16'(len),
                   $urandom_range(0, 9) == 0);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || due_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_events.size() != 0) begin
      $error("%0d expected results never arrived", due_events.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
